@@ hdl/kwm_pkg.sv @@
package kwm_pkg;

    localparam int LISTS_DEF  = 8;
    localparam int DATA_WIDTH = 32;
    localparam int SRC_W      = 3;
    localparam int CFG_W      = 4;
    localparam logic [CFG_W-1:0] NUM_LISTS_RST = 4'd8;

    typedef struct packed {
        logic [SRC_W-1:0]             list_id;
        logic signed [DATA_WIDTH-1:0] value;
        logic                         present;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] out_value;
        logic [SRC_W-1:0]             source_list;
        logic                         done_res;
    } t_out_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic [SRC_W-1:0]             src;
    } t_entry;

    // true if entry a leaves before entry b
    function automatic logic goes_first(t_entry a, t_entry b);
        logic lt;
        lt = (a.value < b.value) || ((a.value == b.value) && (a.src < b.src));
        return lt;
    endfunction

endpackage

@@ hdl/k_way_sorted_merge_top.sv @@
// K-way sorted merge over up to LISTS ascending streams.
// Input channel (i_in_valid / o_in_ready / i_in_data): one item per transfer.
// The first num_lists items are the stream heads; no result follows them
// except the one completing the heads. After that each item gives exactly
// one result: the smallest held value and its source stream, which must
// supply the next item, or a done result when nothing is held.
// Output channel (o_out_valid / i_out_ready / o_out_data) is one register.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes
// num_lists; it is always ready and must be used only while idle.
// Held values live in one RAM with a registered read. An item is
// inserted in the idle state; then the minimum search reads each held
// entry once, the last entry is read and written back into the freed
// slot, and the output register is loaded. A done result skips the
// search and goes straight to the output register.
// A new item is taken while the previous result still waits for transfer;
// the emit step waits until the output register is free.
// Reset (synchronous, active low) empties the held set, clears the head
// count and sets num_lists to 8. RAM contents need no reset.
module k_way_sorted_merge_top #(
    parameter int LISTS = kwm_pkg::LISTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  kwm_pkg::t_in_item        i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output kwm_pkg::t_out_item       o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [kwm_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(LISTS);
    localparam int CNT_W = $clog2(LISTS + 1);
    localparam int NW    = (CNT_W > kwm_pkg::CFG_W) ? CNT_W : kwm_pkg::CFG_W;
    localparam int EW    = kwm_pkg::DATA_WIDTH + kwm_pkg::SRC_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_MOVE  = 5'b00100,
        S_WRITE = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [kwm_pkg::CFG_W-1:0] r_num, n_num;
    logic [kwm_pkg::CFG_W-1:0] r_heads, n_heads;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_pend_idx, n_pend_idx;
    logic r_pend, n_pend;
    logic r_best_vld, n_best_vld;
    logic [CNT_W-1:0] r_best_idx, n_best_idx;
    kwm_pkg::t_entry r_best, n_best;
    logic r_done, n_done;
    logic r_ov, n_ov;
    kwm_pkg::t_out_item r_out, n_out;

    logic we;
    logic [IDX_W-1:0] waddr, raddr;
    kwm_pkg::t_entry wdata, rdata;
    logic [EW-1:0] rdata_raw;
    logic [kwm_pkg::CFG_W-1:0] active;
    logic in_fire;

    kwm_ram #(
        .WIDTH (EW),
        .DEPTH (LISTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );
    assign rdata = kwm_pkg::t_entry'(rdata_raw);

    // clamp stream count to 1..LISTS
    always_comb begin
        if (r_num == '0) begin
            active = kwm_pkg::CFG_W'(1);
        end else if (NW'(r_num) > NW'(LISTS)) begin
            active = kwm_pkg::CFG_W'(LISTS);
        end else begin
            active = r_num;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // next-state logic
    always_comb begin
        n_state    = r_state;
        n_num      = r_num;
        n_heads    = r_heads;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pend_idx = r_idx;
        n_best_vld = r_best_vld;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_done     = r_done;
        n_ov       = r_ov;
        n_out      = r_out;
        we         = 1'b0;
        waddr      = r_count[IDX_W-1:0];
        wdata      = '{value: i_in_data.value, src: i_in_data.list_id};
        raddr      = r_idx[IDX_W-1:0];

        if (i_cfg_valid) begin
            n_num = i_cfg_data;
        end
        // drop the output once transferred
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.present && (r_count < CNT_W'(LISTS))) begin
                        we      = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                    n_idx      = '0;
                    n_best_vld = 1'b0;
                    if (r_heads < active) begin
                        n_heads = r_heads + kwm_pkg::CFG_W'(1);
                    end
                    if ((r_heads < active) && (n_heads < active)) begin
                        n_state = S_IDLE;
                    end else if (n_count == '0) begin
                        n_done  = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_done  = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // compare the entry read last cycle
                if (r_pend && (!r_best_vld || kwm_pkg::goes_first(rdata, r_best))) begin
                    n_best_vld = 1'b1;
                    n_best     = rdata;
                    n_best_idx = r_pend_idx;
                end
                // issue the next read
                if (r_idx != r_count) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                    n_idx      = r_idx + CNT_W'(1);
                end else if (!r_pend) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                raddr   = IDX_W'(r_count - CNT_W'(1));
                n_state = S_WRITE;
            end
            S_WRITE: begin
                // move the last entry into the freed slot
                we      = 1'b1;
                waddr   = r_best_idx[IDX_W-1:0];
                wdata   = rdata;
                n_count = r_count - CNT_W'(1);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ov || i_out_ready) begin
                    n_ov = 1'b1;
                    if (r_done) begin
                        n_out = '{out_value: '0, source_list: '0, done_res: 1'b1};
                    end else begin
                        n_out = '{out_value: r_best.value, source_list: r_best.src,
                                  done_res: 1'b0};
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_num      <= kwm_pkg::NUM_LISTS_RST;
            r_heads    <= '0;
            r_count    <= '0;
            r_pend     <= 1'b0;
            r_best_vld <= 1'b0;
            r_ov       <= 1'b0;
            r_idx      <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_num      <= n_num;
            r_heads    <= n_heads;
            r_count    <= n_count;
            r_pend     <= n_pend;
            r_best_vld <= n_best_vld;
            r_ov       <= n_ov;
            r_idx      <= n_idx;
            r_done     <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_out      <= n_out;
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LISTS))
        else $error("held count above capacity");

    a_write_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("write-back did not shrink held set");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.done_res) |-> (r_out.out_value == '0 && r_out.source_list == '0))
        else $error("done result carries data");

    a_emit_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |-> (r_best_vld && r_count != '0))
        else $error("removal without a held minimum");

endmodule

@@ hdl/kwm_ram.sv @@
module kwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sim/k_way_sorted_merge_top_tb.sv @@
`timescale 1ns / 1ps

// Predicts the merged stream and keeps the results still owed by the block
class merge_scoreboard;
    kwm_pkg::t_entry           held[kwm_pkg::LISTS_DEF];
    int unsigned               held_n;
    int unsigned               heads_seen;
    logic [kwm_pkg::CFG_W-1:0] lists_cfg;
    kwm_pkg::t_out_item        owed[$];
    int                        mismatches;

    function new();
        held_n     = 0;
        heads_seen = 0;
        lists_cfg  = kwm_pkg::NUM_LISTS_RST;
        mismatches = 0;
    endfunction

    function void write_lists(logic [kwm_pkg::CFG_W-1:0] v);
        lists_cfg = v;
    endfunction

    // clamp the register into 1..LISTS
    function int unsigned active_lists();
        if (lists_cfg == 0) return 1;
        if (lists_cfg > kwm_pkg::LISTS_DEF) return kwm_pkg::LISTS_DEF;
        return lists_cfg;
    endfunction

    function bit leaves_earlier(kwm_pkg::t_entry a, kwm_pkg::t_entry b);
        if (a.value != b.value) return a.value < b.value;
        return a.src < b.src;
    endfunction

    // note an accepted item; return 1 with the owed result if it causes one
    function bit note_item(kwm_pkg::t_in_item it, output kwm_pkg::t_out_item res);
        int unsigned best;
        int unsigned n;
        n = active_lists();
        res = '0;
        if (it.present && held_n < kwm_pkg::LISTS_DEF) begin
            held[held_n].value = it.value;
            held[held_n].src   = it.list_id;
            held_n++;
        end
        if (heads_seen < n) begin
            heads_seen++;
            if (heads_seen < n) return 0;
        end
        if (held_n == 0) begin
            res.done_res = 1'b1;
        end else begin
            best = 0;
            for (int unsigned i = 1; i < held_n; i++)
                if (leaves_earlier(held[i], held[best])) best = i;
            res.out_value   = held[best].value;
            res.source_list = held[best].src;
            held_n--;
            held[best] = held[held_n];
        end
        owed.push_back(res);
        return 1;
    endfunction

    // compare a transferred result with the oldest owed one
    function void check_result(kwm_pkg::t_out_item got);
        kwm_pkg::t_out_item exp_r;
        if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: value %0d src %0d done %0b",
                         got.out_value, got.source_list, got.done_res);
            return;
        end
        exp_r = owed.pop_front();
        if (got.out_value !== exp_r.out_value || got.source_list !== exp_r.source_list ||
            got.done_res !== exp_r.done_res) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: exp value %0d src %0d done %0b, got %0d %0d %0b",
                         exp_r.out_value, exp_r.source_list, exp_r.done_res,
                         got.out_value, got.source_list, got.done_res);
        end
    endfunction
endclass

module k_way_sorted_merge_top_tb;

    localparam int STALL_LIMIT = 2000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    kwm_pkg::t_in_item         i_in_data = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    kwm_pkg::t_out_item        o_out_data;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [kwm_pkg::CFG_W-1:0] i_cfg_data = '0;

    merge_scoreboard  sb;
    bit               no_idle = 1'b0;
    int               stall_cycles = 0;

    // per-stream generator state
    logic signed [kwm_pkg::DATA_WIDTH-1:0] stream_val[kwm_pkg::LISTS_DEF];
    int                                    stream_left[kwm_pkg::LISTS_DEF];
    bit                                    stream_fresh[kwm_pkg::LISTS_DEF];
    logic [kwm_pkg::SRC_W-1:0]             want_list = '0;

    k_way_sorted_merge_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // check results and stall the output at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
        i_out_ready <= no_idle || ($urandom_range(99) >= 26);
    end

    // end the run when nothing transfers for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic void refill(int l);
        stream_left[l]  = int'($urandom_range(12));
        stream_fresh[l] = 1'b1;
    endfunction

    // next element of one ascending stream, or an empty marker
    function automatic kwm_pkg::t_in_item stream_next(logic [kwm_pkg::SRC_W-1:0] l);
        kwm_pkg::t_in_item  it;
        logic signed [32:0] sum;
        int                 pick;
        it = '0;
        it.list_id = l;
        if (stream_left[l] == 0) begin
            it.value = $urandom;
            return it;
        end
        pick = $urandom_range(9);
        if (stream_fresh[l]) begin
            stream_fresh[l] = 1'b0;
            if (pick == 0) stream_val[l] = 32'sh8000_0000;
            else if (pick == 1) stream_val[l] = 32'sh7fff_fff0;
            else if (pick < 5) stream_val[l] = $signed($urandom_range(40)) - 20;
            else stream_val[l] = $urandom;
        end else begin
            if (pick < 3) sum = stream_val[l];
            else if (pick < 7)
                sum = stream_val[l] + $signed(33'($urandom_range(1, 15)));
            else
                sum = stream_val[l] + $signed(33'($urandom_range(1, 1 << 24)));
            if (sum > 33'sh0_7fff_ffff) begin
                stream_left[l] = 0;
                it.value = $urandom;
                return it;
            end
            stream_val[l] = sum[31:0];
        end
        stream_left[l]--;
        it.value   = stream_val[l];
        it.present = 1'b1;
        return it;
    endfunction

    // offer one item, hold it until the transfer, and predict it
    task automatic send_item(kwm_pkg::t_in_item it);
        kwm_pkg::t_out_item res;
        if (!no_idle)
            while ($urandom_range(99) < 26) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (sb.note_item(it, res)) begin
            if (res.done_res) begin
                want_list = kwm_pkg::SRC_W'($urandom_range(kwm_pkg::LISTS_DEF - 1));
                refill(want_list);
            end else begin
                want_list = res.source_list;
            end
        end
    endtask

    // drain the block, then write num_lists
    task automatic write_lists(logic [kwm_pkg::CFG_W-1:0] v);
        i_in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (kwm_pkg::LISTS_DEF + 12) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_lists(v);
        i_cfg_valid <= 1'b0;
        for (int l = 0; l < kwm_pkg::LISTS_DEF; l++) refill(l);
    endtask

    task automatic send_fixed(int l, logic signed [kwm_pkg::DATA_WIDTH-1:0] v, bit p);
        kwm_pkg::t_in_item it;
        it.list_id = kwm_pkg::SRC_W'(l);
        it.value   = v;
        it.present = p;
        send_item(it);
    endtask

    // mostly well-formed merge traffic, some noise
    task automatic random_phase(int items, bit pause_once);
        kwm_pkg::t_in_item it;
        for (int k = 0; k < items; k++) begin
            if (pause_once && k == items / 2) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.owed.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(99) < 15) begin
                it.list_id = kwm_pkg::SRC_W'($urandom);
                it.value   = $urandom;
                it.present = 1'($urandom);
            end else if (sb.heads_seen < sb.active_lists()) begin
                it = stream_next(sb.heads_seen[kwm_pkg::SRC_W-1:0]);
            end else begin
                it = stream_next(want_list);
            end
            send_item(it);
        end
    endtask

    initial begin
        logic [kwm_pkg::CFG_W-1:0] plan[7] = '{4'd5, 4'd8, 4'd2, 4'd15, 4'd1, 4'd9, 4'd8};
        sb = new();
        for (int l = 0; l < kwm_pkg::LISTS_DEF; l++) refill(l);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a zero register acts as one stream: each item emits at once
        write_lists(4'd0);
        send_fixed(0, 32'sh7fff_ffff, 1'b1);
        send_fixed(0, 32'sh8000_0000, 1'b1);
        send_fixed(7, 32'sd0, 1'b0);
        send_fixed(5, 32'sd1, 1'b0);
        send_fixed(7, 32'shffff_ffff, 1'b1);

        // raise to three streams: two more heads, tie broken by list id
        write_lists(4'd3);
        send_fixed(2, 32'sd5, 1'b1);
        send_fixed(0, 32'sd5, 1'b1);
        send_fixed(0, 32'sd0, 1'b0);
        send_fixed(2, 32'sh8000_0000, 1'b1);
        send_fixed(2, 32'sd0, 1'b0);
        send_fixed(2, 32'sd0, 1'b0);
        send_fixed(6, 32'sh7fff_ffff, 1'b1);
        send_fixed(1, 32'sh7fff_ffff, 1'b1);

        for (int p = 0; p < 7; p++) begin
            write_lists(plan[p]);
            no_idle = (p == 3);
            random_phase(190, p == 1);
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (kwm_pkg::LISTS_DEF + 30) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ k_way_sorted_merge_top.f @@
hdl/kwm_pkg.sv
hdl/kwm_ram.sv
hdl/k_way_sorted_merge_top.sv
sim/k_way_sorted_merge_top_tb.sv
